// ===== rtl/weighted_random_select_unit_defines.svh =====
// ----------------------------------------------------------------------------
// weighted_random_select_unit_defines
// Assertion macros shared by the weighted random select checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_SELECT_UNIT_DEFINES_SVH
`define WEIGHTED_RANDOM_SELECT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define WRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wrs check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define WRS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wrs check failed");

`endif

// ===== rtl/wrs_pkg.sv =====
// ----------------------------------------------------------------------------
// wrs_pkg
// Types and constants for the weighted random select unit.
// ----------------------------------------------------------------------------
package wrs_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int ACTIVE_W = 7;
  localparam int INDEX_W  = 6;
  localparam int WEIGHT_W = 16;
  localparam int DRAW_W   = 22;

  localparam logic [DRAW_W-1:0] TOTAL_MAX = 22'h3F_FFFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  typedef struct packed {
    logic                op;
    logic [INDEX_W-1:0]  entry_index;
    logic [WEIGHT_W-1:0] entry_weight;
    logic [DRAW_W-1:0]   draw_value;
  } wrs_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] selected_index;
    logic               found;
    logic               empty_error;
    logic [DRAW_W-1:0]  total_weight;
  } wrs_res_t;

endpackage

// ===== rtl/wrs_table.sv =====
// ----------------------------------------------------------------------------
// wrs_table
// Weight store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wrs_table #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/weighted_random_select_unit.sv =====
// ----------------------------------------------------------------------------
// weighted_random_select_unit
// Roulette-wheel selection over a table of weights, one entry per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req and pulse start while busy is low. op selects
//   a weight write (entry_index, entry_weight) or a draw (draw_value).
//   Every command returns one result beat: result_valid is high for exactly
//   one cycle with result on the same cycle. The receiver cannot stall.
//   Config channel: cfg_data carries active_entries, taken when cfg_valid
//   and cfg_ready are both high; cfg_ready is low while busy.
// Timing:
//   A command walks the first N = min(active_entries, MAX_ENTRIES) table
//   entries through one shared add/compare stage, one entry a cycle, behind
//   the table's registered read port. Busy stays high for the whole walk,
//   so commands do not overlap; the result beat appears in the cycle busy
//   drops, so a new command may be issued alongside it.
// Reset:
//   rst clears the sequencer and active_entries. Table contents are not
//   cleared; entries must be written before they take part in a walk.
// ----------------------------------------------------------------------------
module weighted_random_select_unit #(
  parameter int MAX_ENTRIES = wrs_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  wrs_pkg::wrs_req_t              req,
  output logic                           result_valid,
  output wrs_pkg::wrs_res_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wrs_pkg::ACTIVE_W-1:0]   cfg_data
);

  import wrs_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = WEIGHT_BITS + CNT_W;
  localparam int ACC_W = (SUM_W > DRAW_W) ? SUM_W : DRAW_W;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t               state;
  logic [ACTIVE_W-1:0]  active_entries;
  logic                 op;
  logic [DRAW_W-1:0]    draw;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     addr;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;
  logic [ACC_W-1:0]     sum;
  logic                 hit;
  logic [IDX_W-1:0]     sel;

  logic                   accept;
  logic                   issue;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [ACC_W-1:0]       sum_next;
  logic                   hit_now;
  logic [CNT_W-1:0]       count_load;
  logic [31:0]            act32;
  logic [31:0]            idx32;
  logic [31:0]            wgt32;
  logic [31:0]            sel32;
  logic                   wr_en;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  // Write side of the table, applied at the accept edge so the walk sees it.
  assign idx32 = 32'(req.entry_index);
  assign wgt32 = 32'(req.entry_weight);
  assign wr_en = accept && (req.op == OP_WRITE) && (idx32 < 32'(MAX_ENTRIES));

  assign act32      = 32'(active_entries);
  assign count_load = (act32 > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(act32);

  assign issue    = (state == ST_WALK) && (addr != count);
  assign sum_next = sum + ACC_W'(rd_data);
  // first entry whose running prefix sum passes the draw value
  assign hit_now  = rd_vld && (op == OP_DRAW) && !hit && (ACC_W'(draw) < sum_next);
  assign sel32    = 32'(sel);

  wrs_table #(
    .DEPTH  (MAX_ENTRIES),
    .WIDTH  (WEIGHT_BITS),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx32[IDX_W-1:0]),
    .wr_data (wgt32[WEIGHT_BITS-1:0]),
    .rd_en   (issue),
    .rd_addr (addr[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      active_entries <= '0;
      result_valid   <= 1'b0;
      rd_vld         <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        active_entries <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op     <= req.op;
            draw   <= req.draw_value;
            count  <= count_load;
            addr   <= '0;
            sum    <= '0;
            hit    <= 1'b0;
            sel    <= '0;
            rd_vld <= 1'b0;
            state  <= ST_WALK;
          end
        end
        ST_WALK: begin
          rd_vld <= issue;
          rd_idx <= addr[IDX_W-1:0];
          if (issue) begin
            addr <= addr + 1'b1;
          end
          if (rd_vld) begin
            sum <= sum_next;
            if (hit_now) begin
              hit <= 1'b1;
              sel <= rd_idx;
            end
          end
          if (!issue && !rd_vld) begin
            result_valid          <= 1'b1;
            result.selected_index <= hit ? sel32[INDEX_W-1:0] : '0;
            result.found          <= hit;
            result.empty_error    <= (op == OP_DRAW) && (sum == '0);
            result.total_weight   <= (sum > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                               : sum[DRAW_W-1:0];
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/wrs_checker.sv =====
// ----------------------------------------------------------------------------
// wrs_checker
// Port-level checks on the weighted random select unit, bound to the top.
// ----------------------------------------------------------------------------
`include "weighted_random_select_unit_defines.svh"

module wrs_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input wrs_pkg::wrs_res_t result
);

  import wrs_pkg::*;

  // a command always ends in exactly one result beat
  `WRS_ASSERT_IMP(a_done_beat, !$past(rst) && $fell(busy), result_valid)
  `WRS_ASSERT_IMP(a_beat_idle, result_valid, !busy)
  `WRS_ASSERT_NXT(a_beat_single, result_valid, !result_valid)
  `WRS_ASSERT_NXT(a_start_busy, start && !busy, busy && !result_valid)
  // an empty table can never select an entry
  `WRS_ASSERT_IMP(a_empty_nohit, result_valid && result.empty_error,
                  !result.found && (result.total_weight == '0))

endmodule

bind weighted_random_select_unit wrs_checker u_wrs_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
